>>> rtl/av1kf_pkg.sv
package av1kf_pkg;

    // Width of the packet length count; fragment sizes are tracked with one extra bit.
    localparam int PACKET_LEN_BITS = 16;
    // Longest leb128 size field that is accepted.
    localparam int LEB_MAX_BYTES   = 10;

    localparam int ACC_W   = PACKET_LEN_BITS + 1;
    localparam int CNT_W   = $clog2(LEB_MAX_BYTES + 1);
    localparam int SHIFT_W = $clog2(7 * LEB_MAX_BYTES);
    localparam int SUM_W   = ACC_W + 8;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [CNT_W-1:0] LEB_MAX = CNT_W'(LEB_MAX_BYTES);

    // OBU type of a sequence header.
    localparam logic [3:0] OBU_TYPE_SEQ_HDR = 4'd1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
    localparam logic [1:0] STATUS_OVERRUN  = 2'd2;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_SIZE,
        PH_HEAD_SIZED,
        PH_SKIP,
        PH_HEAD_REST,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [1:0] status;
        logic       key_frame;
        logic       last_in_frame;
        logic       first_in_frame;
    } t_result;

endpackage

>>> rtl/av1kf_parser.sv
module av1kf_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_data_byte,
    input  logic                i_packet_start,
    input  logic                i_packet_end,
    output logic                o_res_valid,
    output av1kf_pkg::t_result  o_res
);

    av1kf_pkg::t_phase r_phase, n_phase;
    logic [1:0]                       r_obu_cnt, n_obu_cnt;
    logic                             r_starts, n_starts;
    logic                             r_ends, n_ends;
    logic [1:0]                       r_frag_idx, n_frag_idx;
    logic [av1kf_pkg::ACC_W-1:0]      r_acc, n_acc;
    logic [av1kf_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [av1kf_pkg::ACC_W-1:0]      r_left, n_left;
    logic                             r_key, n_key;
    logic [1:0]                       r_err, n_err;

    logic                             seq_hdr;
    logic [av1kf_pkg::SHIFT_W-1:0]    shift;
    logic [av1kf_pkg::SUM_W-1:0]      sum;
    logic [av1kf_pkg::ACC_W-1:0]      sat_acc;
    logic [av1kf_pkg::CNT_W-1:0]      cnt_inc;
    logic [av1kf_pkg::ACC_W-1:0]      left_dec;
    av1kf_pkg::t_phase                bf_phase;
    logic [1:0]                       bf_idx;

    // OBU header type check.
    assign seq_hdr = (i_data_byte[6:3] == av1kf_pkg::OBU_TYPE_SEQ_HDR);

    // Saturating leb128 accumulation of one size byte.
    always_comb begin
        shift   = av1kf_pkg::SHIFT_W'(r_cnt) * av1kf_pkg::SHIFT_W'(7);
        sum     = av1kf_pkg::SUM_W'(r_acc)
                + (av1kf_pkg::SUM_W'(i_data_byte[6:0]) << shift);
        cnt_inc = r_cnt + av1kf_pkg::CNT_W'(1);
        if (i_data_byte[6:0] == 7'd0) begin
            sat_acc = r_acc;
        end else if (shift >= av1kf_pkg::SHIFT_W'(av1kf_pkg::ACC_W)) begin
            sat_acc = av1kf_pkg::ACC_MAX;
        end else if (sum > av1kf_pkg::SUM_W'(av1kf_pkg::ACC_MAX)) begin
            sat_acc = av1kf_pkg::ACC_MAX;
        end else begin
            sat_acc = sum[av1kf_pkg::ACC_W-1:0];
        end
        left_dec = r_left - av1kf_pkg::ACC_W'(1);
    end

    // Next fragment: the one matching the OBU count is the rest; none after the second.
    always_comb begin
        bf_idx = r_frag_idx + 2'd1;
        if (r_frag_idx >= 2'd2) begin
            bf_phase = av1kf_pkg::PH_DONE;
            bf_idx   = r_frag_idx;
        end else if (bf_idx == r_obu_cnt) begin
            bf_phase = av1kf_pkg::PH_HEAD_REST;
        end else begin
            bf_phase = av1kf_pkg::PH_SIZE;
        end
    end

    // Next state and result for the byte in the input register.
    always_comb begin
        n_phase    = r_phase;
        n_obu_cnt  = r_obu_cnt;
        n_starts   = r_starts;
        n_ends     = r_ends;
        n_frag_idx = r_frag_idx;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_left     = r_left;
        n_key      = r_key;
        n_err      = r_err;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_valid) begin
            if (i_packet_start || r_phase == av1kf_pkg::PH_HDR) begin
                // Aggregation header byte.
                n_key      = 1'b0;
                n_err      = av1kf_pkg::STATUS_OK;
                n_acc      = '0;
                n_cnt      = '0;
                n_left     = '0;
                n_frag_idx = 2'd0;
                n_starts   = ~i_data_byte[7];
                n_ends     = ~i_data_byte[6];
                n_obu_cnt  = i_data_byte[5:4];
                if (!i_data_byte[7]) begin
                    n_frag_idx = 2'd1;
                    if (i_data_byte[5:4] == 2'd1) begin
                        n_phase = av1kf_pkg::PH_HEAD_REST;
                    end else begin
                        n_phase = av1kf_pkg::PH_SIZE;
                    end
                end else begin
                    n_phase = av1kf_pkg::PH_DONE;
                end
            end else begin
                case (r_phase)
                    av1kf_pkg::PH_SIZE: begin
                        n_acc = sat_acc;
                        n_cnt = cnt_inc;
                        if (i_data_byte[7]) begin
                            if (cnt_inc >= av1kf_pkg::LEB_MAX) begin
                                n_err   = av1kf_pkg::STATUS_BAD_SIZE;
                                n_phase = av1kf_pkg::PH_DONE;
                            end
                        end else if (sat_acc == av1kf_pkg::ACC_MAX) begin
                            n_err   = av1kf_pkg::STATUS_OVERRUN;
                            n_phase = av1kf_pkg::PH_DONE;
                        end else if (sat_acc == '0) begin
                            // Zero-size fragment is skipped.
                            n_phase    = bf_phase;
                            n_frag_idx = bf_idx;
                            n_acc      = '0;
                            n_cnt      = '0;
                        end else begin
                            n_left  = sat_acc;
                            n_phase = av1kf_pkg::PH_HEAD_SIZED;
                        end
                    end
                    av1kf_pkg::PH_HEAD_SIZED, av1kf_pkg::PH_SKIP: begin
                        if (r_phase == av1kf_pkg::PH_HEAD_SIZED && seq_hdr) begin
                            n_key = 1'b1;
                        end
                        n_left = left_dec;
                        if (left_dec == '0) begin
                            if (n_key) begin
                                n_phase = av1kf_pkg::PH_DONE;
                            end else begin
                                n_phase    = bf_phase;
                                n_frag_idx = bf_idx;
                                n_acc      = '0;
                                n_cnt      = '0;
                            end
                        end else begin
                            n_phase = av1kf_pkg::PH_SKIP;
                        end
                    end
                    av1kf_pkg::PH_HEAD_REST: begin
                        if (seq_hdr) begin
                            n_key = 1'b1;
                        end
                        n_phase = av1kf_pkg::PH_DONE;
                    end
                    default: begin
                    end
                endcase
            end

            // Packet end: classify truncation, then report.
            if (i_packet_end) begin
                if (n_err == av1kf_pkg::STATUS_OK) begin
                    if (n_phase == av1kf_pkg::PH_SIZE && n_cnt != '0) begin
                        n_err = av1kf_pkg::STATUS_BAD_SIZE;
                    end else if (n_phase == av1kf_pkg::PH_HEAD_SIZED
                              || n_phase == av1kf_pkg::PH_SKIP) begin
                        n_err = av1kf_pkg::STATUS_OVERRUN;
                    end
                end
                o_res_valid          = 1'b1;
                o_res.first_in_frame = n_starts;
                o_res.last_in_frame  = n_ends;
                o_res.key_frame      = (n_err == av1kf_pkg::STATUS_OK) && n_key;
                o_res.status         = n_err;
                n_phase              = av1kf_pkg::PH_HDR;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= av1kf_pkg::PH_HDR;
            r_obu_cnt  <= '0;
            r_starts   <= 1'b0;
            r_ends     <= 1'b0;
            r_frag_idx <= '0;
            r_acc      <= '0;
            r_cnt      <= '0;
            r_left     <= '0;
            r_key      <= 1'b0;
            r_err      <= av1kf_pkg::STATUS_OK;
        end else begin
            r_phase    <= n_phase;
            r_obu_cnt  <= n_obu_cnt;
            r_starts   <= n_starts;
            r_ends     <= n_ends;
            r_frag_idx <= n_frag_idx;
            r_acc      <= n_acc;
            r_cnt      <= n_cnt;
            r_left     <= n_left;
            r_key      <= n_key;
            r_err      <= n_err;
        end
    end

endmodule

>>> rtl/av1_rtp_keyframe_classifier_core.sv
// AV1 RTP aggregation header parser and key frame classifier.
//
// Input channel (s_axis): one payload byte per transfer in s_axis_tdata, the
// aggregation header first. s_axis_tuser marks the first byte of a payload and
// s_axis_tlast marks the last one. A start mark in mid-packet drops the packet.
// Output channel (m_axis): one transfer per packet, made for the byte marked
// by s_axis_tlast, giving the Z and Y frame flags, the key frame flag and a
// status (ok, unreadable leb128 size, or size past the end of the payload).
//
// Each byte passes an input register, then the parser updates its state and,
// on the last byte, loads the result register. One byte is taken every cycle
// unless an end byte waits for the result register; the parser updates its
// state once for each byte taken.
// When m_axis_tready is low, the result waits in the output register while
// bytes that end no packet keep flowing; an end byte waits in the input
// register until the result register is free.
// Synchronous reset (i_rst_n low) empties both registers and returns the
// parser to waiting for an aggregation header.
module av1_rtp_keyframe_classifier_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] packet_start
    input  logic       s_axis_tlast,   // packet_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] first_in_frame, [1] last_in_frame,
                                       // [2] key_frame, [4:3] status, [7:5] zero
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_start;
    logic               r_in_end;
    logic               r_out_valid;
    av1kf_pkg::t_result r_out;

    logic               advance;
    logic               res_valid;
    av1kf_pkg::t_result res;

    // A byte moves on unless it ends a packet and the result register is full and not being taken.
    assign advance       = r_in_valid && (!r_in_end || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
            r_in_end   <= s_axis_tlast;
        end
    end

    av1kf_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (advance),
        .i_data_byte    (r_in_byte),
        .i_packet_start (r_in_start),
        .i_packet_end   (r_in_end),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

endmodule

>>> verif/av1_rtp_keyframe_classifier_core_test.sv
module av1_rtp_keyframe_classifier_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    // A sequence header OBU header byte with the has_size bit set.
    localparam logic [7:0] SEQ_HDR_OBU = {1'b0, av1kf_pkg::OBU_TYPE_SEQ_HDR, 3'b010};

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] data_byte
    logic       s_axis_tuser;   // [0] packet_start
    logic       s_axis_tlast;   // packet_end
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;   // [0] first_in_frame, [1] last_in_frame,
                                // [2] key_frame, [4:3] status, [7:5] zero

    int src_idle_pct;
    int dst_idle_pct;
    int n_fail;
    int n_sent;

    av1_rtp_keyframe_classifier_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("[av1_rtp_keyframe_classifier_core] ERROR");
        $finish;
    end

    // Parser state of the predictor.
    av1kf_pkg::t_phase           ph;
    logic [1:0]                  obu_w;
    logic                        z_clear;
    logic                        y_clear;
    logic [1:0]                  frag_idx;
    logic [av1kf_pkg::ACC_W-1:0] size_acc;
    int                          size_len;
    logic [av1kf_pkg::ACC_W-1:0] frag_left;
    logic                        seq_seen;
    logic [1:0]                  err_code;

    av1kf_pkg::t_result pending_packet_results[$];

    function automatic void clear_parser();
        ph        = av1kf_pkg::PH_HDR;
        obu_w     = '0;
        z_clear   = 1'b0;
        y_clear   = 1'b0;
        frag_idx  = '0;
        size_acc  = '0;
        size_len  = 0;
        frag_left = '0;
        seq_seen  = 1'b0;
        err_code  = av1kf_pkg::STATUS_OK;
    endfunction

    // Only the first two fragments are examined.
    function automatic void next_fragment();
        if (frag_idx >= 2'd2) begin
            ph = av1kf_pkg::PH_DONE;
        end else begin
            frag_idx = frag_idx + 2'd1;
            if (frag_idx == obu_w) begin
                ph = av1kf_pkg::PH_HEAD_REST;
            end else begin
                ph       = av1kf_pkg::PH_SIZE;
                size_acc = '0;
                size_len = 0;
            end
        end
    endfunction

    // Accumulate one leb128 byte, saturating at the top of the counter.
    function automatic void take_size_byte(input logic [7:0] b);
        logic [31:0] sum;
        int          shift;
        shift = 7 * size_len;
        if (b[6:0] != 7'd0) begin
            if (shift >= av1kf_pkg::ACC_W) begin
                size_acc = av1kf_pkg::ACC_MAX;
            end else begin
                sum      = 32'(size_acc) + (32'(b[6:0]) << shift);
                size_acc = (sum > 32'(av1kf_pkg::ACC_MAX)) ? av1kf_pkg::ACC_MAX
                                                           : sum[av1kf_pkg::ACC_W-1:0];
            end
        end
        size_len++;
        if (b[7]) begin
            if (size_len >= av1kf_pkg::LEB_MAX_BYTES) begin
                err_code = av1kf_pkg::STATUS_BAD_SIZE;
                ph       = av1kf_pkg::PH_DONE;
            end
        end else if (size_acc >= av1kf_pkg::ACC_MAX) begin
            err_code = av1kf_pkg::STATUS_OVERRUN;
            ph       = av1kf_pkg::PH_DONE;
        end else if (size_acc == '0) begin
            next_fragment();
        end else begin
            frag_left = size_acc;
            ph        = av1kf_pkg::PH_HEAD_SIZED;
        end
    endfunction

    function automatic void consume_sized();
        frag_left = frag_left - av1kf_pkg::ACC_W'(1);
        if (frag_left == '0) begin
            if (seq_seen) begin
                ph = av1kf_pkg::PH_DONE;
            end else begin
                next_fragment();
            end
        end else begin
            ph = av1kf_pkg::PH_SKIP;
        end
    endfunction

    // Advance the predicted parser by one byte; a packet end queues a result.
    function automatic void classify_byte(input logic [7:0] b, input logic sop,
                                          input logic eop);
        av1kf_pkg::t_result r;
        if (sop || ph == av1kf_pkg::PH_HDR) begin
            clear_parser();
            z_clear = ~b[7];
            y_clear = ~b[6];
            obu_w   = b[5:4];
            if (z_clear) begin
                next_fragment();
            end else begin
                ph = av1kf_pkg::PH_DONE;
            end
        end else begin
            case (ph)
                av1kf_pkg::PH_SIZE: begin
                    take_size_byte(b);
                end
                av1kf_pkg::PH_HEAD_SIZED: begin
                    if (b[6:3] == av1kf_pkg::OBU_TYPE_SEQ_HDR) seq_seen = 1'b1;
                    consume_sized();
                end
                av1kf_pkg::PH_SKIP: begin
                    consume_sized();
                end
                av1kf_pkg::PH_HEAD_REST: begin
                    if (b[6:3] == av1kf_pkg::OBU_TYPE_SEQ_HDR) seq_seen = 1'b1;
                    ph = av1kf_pkg::PH_DONE;
                end
                default: begin
                end
            endcase
        end
        if (eop) begin
            if (err_code == av1kf_pkg::STATUS_OK) begin
                if (ph == av1kf_pkg::PH_SIZE && size_len > 0) begin
                    err_code = av1kf_pkg::STATUS_BAD_SIZE;
                end else if ((ph == av1kf_pkg::PH_HEAD_SIZED || ph == av1kf_pkg::PH_SKIP)
                             && frag_left != '0) begin
                    err_code = av1kf_pkg::STATUS_OVERRUN;
                end
            end
            r.first_in_frame = z_clear;
            r.last_in_frame  = y_clear;
            r.key_frame      = (err_code == av1kf_pkg::STATUS_OK) && seq_seen;
            r.status         = err_code;
            pending_packet_results.push_back(r);
            ph = av1kf_pkg::PH_HDR;
        end
    endfunction

    function automatic void check_field(input string name, input logic [2:0] want,
                                        input logic [2:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    // Compare every result transfer with the oldest predicted one.
    always @(posedge i_clk) begin
        av1kf_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_packet_results.size() == 0) begin
                $error("result transfer with none expected: tdata expected none, got %h",
                       m_axis_tdata);
                n_fail++;
            end else begin
                want = pending_packet_results.pop_front();
                check_field("first_in_frame", 3'(want.first_in_frame), 3'(m_axis_tdata[0]));
                check_field("last_in_frame", 3'(want.last_in_frame), 3'(m_axis_tdata[1]));
                check_field("key_frame", 3'(want.key_frame), 3'(m_axis_tdata[2]));
                check_field("status", 3'(want.status), 3'(m_axis_tdata[4:3]));
                check_field("tdata padding", 3'b000, m_axis_tdata[7:5]);
            end
        end
    end

    // The receiver stalls at random.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Send one byte; entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic sop, input logic eop);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= sop;
        s_axis_tlast  <= eop;
        do @(posedge i_clk); while (!s_axis_tready);
        classify_byte(b, sop, eop);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_packet(input logic [7:0] pkt[$], input bit with_start,
                               input bit with_end);
        foreach (pkt[i]) begin
            send_byte(pkt[i], with_start && i == 0, with_end && i == pkt.size() - 1);
        end
    endtask

    // Hold the input idle until every predicted result has been taken.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_packet_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [7:0] random_obu_header();
        if ($urandom_range(99) < 35) begin
            return {1'($urandom), av1kf_pkg::OBU_TYPE_SEQ_HDR, 3'($urandom)};
        end
        return 8'($urandom);
    endfunction

    task automatic test_frame_flags();
        logic [7:0] pkt[$];
        // Continuation packets: Z set, with and without Y.
        pkt = '{8'h80};
        send_packet(pkt, 1, 1);
        pkt = '{8'hFF};
        send_packet(pkt, 1, 1);
        // Header only with Z clear: nothing to walk, status ok.
        pkt = '{8'h70};
        send_packet(pkt, 1, 1);
        // No start mark: the byte after a packet end is still a header.
        pkt = '{8'h10, SEQ_HDR_OBU};
        send_packet(pkt, 0, 1);
    endtask

    task automatic test_key_detection();
        logic [7:0] pkt[$];
        // Sequence header in a sized first fragment.
        pkt = '{8'h00, 8'h01, SEQ_HDR_OBU};
        send_packet(pkt, 1, 1);
        // A start mark in mid-packet drops it; then a zero-size fragment is
        // skipped and the second one is the rest of the packet.
        pkt = '{8'h00, 8'h05, 8'h01};
        send_packet(pkt, 1, 0);
        pkt = '{8'h20, 8'h00, SEQ_HDR_OBU};
        send_packet(pkt, 1, 1);
    endtask

    task automatic test_size_errors();
        logic [7:0] pkt[$];
        // Packet ends inside a size field.
        pkt = '{8'h00, 8'h85};
        send_packet(pkt, 1, 1);
        // Fragment runs past the end; its sequence header does not count.
        pkt = '{8'h00, 8'h03, SEQ_HDR_OBU};
        send_packet(pkt, 1, 1);
        // Size reaching the saturation value.
        pkt = '{8'h00, 8'hFF, 8'hFF, 8'h07};
        send_packet(pkt, 1, 1);
        // Size field still continuing at its last allowed byte.
        pkt = '{8'h00};
        repeat (av1kf_pkg::LEB_MAX_BYTES) pkt.push_back(8'hFF);
        pkt.push_back(8'h00);
        send_packet(pkt, 1, 1);
    endtask

    // One packet, mostly well formed; sometimes noise or a broken one.
    task automatic send_random_packet();
        logic [7:0]  pkt[$];
        logic [7:0]  hdr;
        logic [7:0]  b;
        int unsigned size;
        int unsigned v;
        int unsigned roll;
        int          pad;
        int          n_body;
        bit          done;
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'($urandom), 1'($urandom));
            return;
        end
        hdr = 8'($urandom);
        if ($urandom_range(99) < 80) hdr[7] = 1'b0;
        pkt.push_back(hdr);
        done = hdr[7];
        if (done) repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
        for (int i = 1; i <= 3 && !done; i++) begin
            if (i == int'(hdr[5:4])) begin
                pkt.push_back(random_obu_header());
                repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
                done = 1;
            end else begin
                roll = $urandom_range(99);
                pad  = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0;
                if (roll < 12) begin
                    size = 0;
                end else if (roll < 80) begin
                    size = $urandom_range(1, 6);
                end else if (roll < 86) begin
                    size = $urandom_range(1)
                         ? $urandom_range(int'(av1kf_pkg::ACC_MAX) - 1, 200000)
                         : $urandom_range(200000, 32'h0FFF_FFFF);
                end else if (roll < 91) begin
                    size = $urandom_range(7, 300);
                end else if (roll < 96) begin
                    // Padded size field around the byte limit.
                    size = $urandom_range(0, 6);
                    pad  = av1kf_pkg::LEB_MAX_BYTES - 1 + $urandom_range(0, 2);
                end else begin
                    pkt.push_back(8'h80 | 8'($urandom_range(127)));
                    done = 1;
                end
                if (!done) begin
                    v = size;
                    do begin
                        b = 8'(v & 32'h7F);
                        v = v >> 7;
                        if (v != 0 || pad > 0) b[7] = 1'b1;
                        pkt.push_back(b);
                    end while (v != 0);
                    while (pad > 0) begin
                        pad--;
                        pkt.push_back((pad > 0) ? 8'h80 : 8'h00);
                    end
                    // Large sizes and some small ones end the packet early.
                    if (size >= 7) begin
                        n_body = $urandom_range(0, 6);
                        done   = 1;
                    end else if (size > 0 && $urandom_range(9) == 0) begin
                        n_body = $urandom_range(0, size - 1);
                        done   = 1;
                    end else begin
                        n_body = size;
                    end
                    for (int k = 0; k < n_body; k++) begin
                        pkt.push_back((k == 0) ? random_obu_header() : 8'($urandom));
                    end
                end
            end
        end
        send_packet(pkt, $urandom_range(19) != 0, $urandom_range(19) != 0);
    endtask

    task automatic test_random_traffic(input int src_pct, input int dst_pct,
                                       input int n_bytes);
        int stop_at;
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        stop_at      = n_sent + n_bytes;
        while (n_sent < stop_at) send_random_packet();
        wait_for_results();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        src_idle_pct  = 6;
        dst_idle_pct  = 86;
        n_fail        = 0;
        n_sent        = 0;
        clear_parser();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_frame_flags();
        test_key_detection();
        test_size_errors();
        wait_for_results();
        test_random_traffic(6, 86, 630);
        test_random_traffic(86, 6, 630);
        test_random_traffic(0, 0, 640);

        if (n_fail == 0) begin
            $display("[av1_rtp_keyframe_classifier_core] OK");
        end else begin
            $display("[av1_rtp_keyframe_classifier_core] ERROR");
        end
        $finish;
    end

endmodule
